// ===== src/wscfe_pkg.sv =====
// shared types and constants for the websocket client frame encoder
package wscfe_pkg;

  localparam int unsigned LEN_W         = 63;
  localparam int unsigned KEY_W         = 32;
  localparam int unsigned HDR_IDX_W     = 4;

  localparam logic [7:0]       HDR_FIN_TEXT = 8'h81;
  localparam logic [7:0]       MASK_BIT     = 8'h80;
  localparam logic [6:0]       LEN_CODE_16  = 7'd126;
  localparam logic [6:0]       LEN_CODE_64  = 7'd127;
  localparam logic [LEN_W-1:0] SHORT_MAX    = 63'd125;
  localparam logic [LEN_W-1:0] MID_MAX      = 63'd65535;

  // position of the first mask key byte for each length class
  localparam logic [HDR_IDX_W-1:0] KEY_POS_SHORT = 4'd2;
  localparam logic [HDR_IDX_W-1:0] KEY_POS_MID   = 4'd4;
  localparam logic [HDR_IDX_W-1:0] KEY_POS_LONG  = 4'd10;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_DATA  = 1'b1
  } req_t;

  typedef enum logic {
    CMD_HEADER = 1'b0,
    CMD_DATA   = 1'b1
  } cmd_kind_t;

  typedef enum logic [1:0] {
    LEN_SHORT = 2'd0,
    LEN_MID   = 2'd1,
    LEN_LONG  = 2'd2
  } len_class_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic             err;
    logic             fend;
    len_class_t       lcls;
    logic [LEN_W-1:0] len;
    logic [KEY_W-1:0] key;
    logic [7:0]       dbyte;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== src/wscfe_in_if.sv =====
// request channel: frame starts and payload bytes
interface wscfe_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [62:0] payload_length;
  logic [31:0] mask_key;
  logic [7:0]  data_byte;

  modport source (output valid, req_type, payload_length, mask_key, data_byte, input ready);
  modport sink   (input valid, req_type, payload_length, mask_key, data_byte, output ready);
endinterface

// ===== src/wscfe_out_if.sv =====
// frame byte channel
interface wscfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_header;
  logic       run_last;
  logic       frame_end;
  logic       error;

  modport source (output valid, out_byte, is_header, run_last, frame_end, error, input ready);
  modport sink   (input valid, out_byte, is_header, run_last, frame_end, error, output ready);
endinterface

// ===== src/wscfe_front.sv =====
// front end: accepts requests, tracks the open frame and issues byte commands
module wscfe_front (
  input  logic                 clk,
  input  logic                 rst_n,
  wscfe_in_if.sink             in_ch,
  input  wscfe_pkg::q_stat_t   q_stat,
  output logic                 push,
  output wscfe_pkg::cmd_t      cmd
);

  logic [wscfe_pkg::LEN_W-1:0] rem_r, rem_nxt, rem_dec;
  logic [wscfe_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [1:0]                  phase_r, phase_nxt;
  logic                        open_r, open_nxt;
  logic                        accept;
  logic [7:0]                  kbyte;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign rem_dec     = rem_r - 63'd1;
  assign kbyte       = key_r[{~phase_r, 3'b000} +: 8];

  always_comb begin
    rem_nxt   = rem_r;
    key_nxt   = key_r;
    phase_nxt = phase_r;
    open_nxt  = open_r;
    push      = 1'b0;
    cmd       = '0;
    cmd.kind  = wscfe_pkg::CMD_DATA;
    cmd.lcls  = wscfe_pkg::LEN_SHORT;
    if (accept) begin
      push = 1'b1;
      if (in_ch.req_type == wscfe_pkg::REQ_START) begin
        cmd.kind = wscfe_pkg::CMD_HEADER;
        cmd.len  = in_ch.payload_length;
        cmd.key  = in_ch.mask_key;
        cmd.fend = (in_ch.payload_length == '0);
        if (in_ch.payload_length <= wscfe_pkg::SHORT_MAX) begin
          cmd.lcls = wscfe_pkg::LEN_SHORT;
        end else if (in_ch.payload_length <= wscfe_pkg::MID_MAX) begin
          cmd.lcls = wscfe_pkg::LEN_MID;
        end else begin
          cmd.lcls = wscfe_pkg::LEN_LONG;
        end
        key_nxt   = in_ch.mask_key;
        phase_nxt = 2'd0;
        rem_nxt   = in_ch.payload_length;
        open_nxt  = (in_ch.payload_length != '0);
      end else if (!open_r) begin
        cmd.err = 1'b1;
      end else begin
        cmd.dbyte = in_ch.data_byte ^ kbyte;
        cmd.fend  = (rem_dec == '0);
        rem_nxt   = rem_dec;
        phase_nxt = phase_r + 2'd1;
        if (rem_dec == '0) begin
          open_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r   <= '0;
      key_r   <= '0;
      phase_r <= '0;
      open_r  <= 1'b0;
    end else begin
      rem_r   <= rem_nxt;
      key_r   <= key_nxt;
      phase_r <= phase_nxt;
      open_r  <= open_nxt;
    end
  end

endmodule

// ===== src/wscfe_queue.sv =====
// command queue between front and back end
module wscfe_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  wscfe_pkg::cmd_t    wr_cmd,
  input  logic               pop,
  output wscfe_pkg::cmd_t    rd_cmd,
  output wscfe_pkg::q_stat_t q_stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  wscfe_pkg::cmd_t   mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push, do_pop;

  assign q_stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign rd_cmd       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== src/wscfe_back.sv =====
// back end: expands commands into frame bytes and holds the output word
module wscfe_back (
  input  logic               clk,
  input  logic               rst_n,
  input  wscfe_pkg::cmd_t    cmd,
  input  wscfe_pkg::q_stat_t q_stat,
  output logic               pop,
  wscfe_out_if.source        out_ch
);

  logic [wscfe_pkg::HDR_IDX_W-1:0] idx_r, idx_nxt, key_pos;
  logic                            ov_r;
  logic [7:0]                      byte_r, byte_c;
  logic                            hdr_r, last_r, fend_r, err_r;
  logic                            hdr_c, last_c, fend_c, err_c;
  logic                            emit, hlast;
  logic [2:0]                      lsel;
  logic [1:0]                      ksel;
  logic [63:0]                     len64;
  logic [7:0]                      code_byte;

  assign emit  = !q_stat.empty && (!ov_r || out_ch.ready);
  assign len64 = {1'b0, cmd.len};
  assign hlast = (idx_r == key_pos + 4'd3);
  assign lsel  = 3'(key_pos - 4'd1 - idx_r);
  assign ksel  = 2'(idx_r - key_pos);

  always_comb begin
    unique case (cmd.lcls)
      wscfe_pkg::LEN_SHORT: begin
        key_pos   = wscfe_pkg::KEY_POS_SHORT;
        code_byte = wscfe_pkg::MASK_BIT | {1'b0, cmd.len[6:0]};
      end
      wscfe_pkg::LEN_MID: begin
        key_pos   = wscfe_pkg::KEY_POS_MID;
        code_byte = wscfe_pkg::MASK_BIT | {1'b0, wscfe_pkg::LEN_CODE_16};
      end
      wscfe_pkg::LEN_LONG: begin
        key_pos   = wscfe_pkg::KEY_POS_LONG;
        code_byte = wscfe_pkg::MASK_BIT | {1'b0, wscfe_pkg::LEN_CODE_64};
      end
      default: begin
        key_pos   = wscfe_pkg::KEY_POS_SHORT;
        code_byte = wscfe_pkg::MASK_BIT;
      end
    endcase
  end

  always_comb begin
    byte_c  = cmd.dbyte;
    hdr_c   = 1'b0;
    last_c  = 1'b1;
    fend_c  = cmd.fend;
    err_c   = cmd.err;
    pop     = 1'b0;
    idx_nxt = idx_r;
    if (cmd.kind == wscfe_pkg::CMD_HEADER) begin
      hdr_c  = 1'b1;
      last_c = hlast;
      fend_c = cmd.fend && hlast;
      err_c  = 1'b0;
      if (idx_r == 4'd0) begin
        byte_c = wscfe_pkg::HDR_FIN_TEXT;
      end else if (idx_r == 4'd1) begin
        byte_c = code_byte;
      end else if (idx_r < key_pos) begin
        byte_c = len64[{lsel, 3'b000} +: 8];
      end else begin
        byte_c = cmd.key[{~ksel, 3'b000} +: 8];
      end
      if (emit) begin
        pop     = hlast;
        idx_nxt = hlast ? '0 : idx_r + 4'd1;
      end
    end else begin
      pop = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r <= byte_c;
      hdr_r  <= hdr_c;
      last_r <= last_c;
      fend_r <= fend_c;
      err_r  <= err_c;
    end
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.out_byte  = byte_r;
  assign out_ch.is_header = hdr_r;
  assign out_ch.run_last  = last_r;
  assign out_ch.frame_end = fend_r;
  assign out_ch.error     = err_r;

  // header walk only runs on a queued header command
  a_idx_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != '0) |-> (!q_stat.empty && cmd.kind == wscfe_pkg::CMD_HEADER))
    else $error("header index set without header command");

  // header walk stays inside the current header
  a_idx_rng: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != '0) |-> (idx_r <= key_pos + 4'd3))
    else $error("header index past header end");

  // error words are lone non-header words
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && err_r) |-> (!hdr_r && last_r && !fend_r && byte_r == 8'd0))
    else $error("malformed error word");

  // payload words always close their request
  a_data_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !hdr_r) |-> last_r)
    else $error("payload word without run_last");

endmodule

// ===== src/websocket_client_frame_encoder.sv =====
// top level of the masked websocket client frame encoder
// usage:
//   in_ch carries requests: req_type 0 starts a text frame with payload_length
//   and mask_key, req_type 1 supplies one unmasked data_byte of the open frame.
//   out_ch carries frame bytes: a start gives 0x81, the length byte with the
//   mask bit, the 16 or 64 bit big-endian extended length when needed, then
//   the four key bytes (6, 8 or 14 words). a payload byte gives one masked
//   word; the frame's final byte has frame_end set. a payload byte with no
//   open frame gives one error word and is dropped.
// timing:
//   a request passes the command queue and then the output word register.
//   payload bytes stream at one word per cycle while out_ch is ready; a start
//   gives header words in order via the back end's single header byte walker.
//   the front end keeps accepting until the command queue is full.
// reset clears the frame state, the queue and the output valid flag.
// when the receiver stalls the output word holds, the queue fills and then
// in_ch.ready drops.
module websocket_client_frame_encoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  wscfe_in_if.sink     in_ch,
  wscfe_out_if.source  out_ch
);

  wscfe_pkg::cmd_t    wr_cmd, rd_cmd;
  wscfe_pkg::q_stat_t q_stat;
  logic               push, pop;

  wscfe_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .push   (push),
    .cmd    (wr_cmd)
  );

  wscfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .q_stat (q_stat)
  );

  wscfe_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (rd_cmd),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
